// ----- sv/fadd_pkg.sv -----
package fadd_pkg;

    // Field widths
    localparam int IN_WIDTH  = 16;
    localparam int PROD_W    = 2 * IN_WIDTH;
    localparam int NSUM_W    = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int CNT_W     = $clog2(MAG_W + 1);
    localparam int SUM_NUM_W = 33;
    localparam int SUM_DEN_W = 31;
    localparam int S_DATA_W  = ((4 * IN_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W  = ((SUM_NUM_W + SUM_DEN_W + 7) / 8) * 8;

    // Program addresses
    typedef enum logic [3:0] {
        STEP_IDLE     = 4'd0,
        STEP_SUM      = 4'd1,
        STEP_TEST     = 4'd2,
        STEP_REM      = 4'd3,
        STEP_REM_WAIT = 4'd4,
        STEP_FIN      = 4'd5,
        STEP_QN_WAIT  = 4'd6,
        STEP_QD       = 4'd7,
        STEP_QD_WAIT  = 4'd8,
        STEP_OUT      = 4'd9
    } step_t;

    // What a step waits on before it retires
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_DIV,
        WAIT_OUT
    } wait_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_YZERO,
        JMP_GZERO
    } cond_t;

    // Divider operand select
    typedef enum logic [1:0] {
        DSEL_XY,
        DSEL_NG,
        DSEL_DG
    } dsel_t;

    // Where the divider result goes
    typedef enum logic [1:0] {
        STORE_NONE,
        STORE_EUCLID,
        STORE_QN,
        STORE_QD
    } store_t;

    typedef struct packed {
        wait_t  wt;
        logic   ld_sum;
        logic   div_go;
        dsel_t  dsel;
        store_t st;
        logic   ld_out;
        cond_t  cond;
        step_t  target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic out_free;
        logic y_zero;
        logic g_zero;
    } status_t;

    localparam ctrl_t CTRL_NOP = '{
        wt:     WAIT_NONE,
        ld_sum: 1'b0,
        div_go: 1'b0,
        dsel:   DSEL_XY,
        st:     STORE_NONE,
        ld_out: 1'b0,
        cond:   JMP_NEXT,
        target: STEP_IDLE
    };

    // Control store
    function automatic ctrl_t ucode_rom(step_t s);
        ctrl_t w;
        w = CTRL_NOP;
        unique case (s)
            STEP_IDLE:
            begin
                w.wt = WAIT_IN;
            end
            STEP_SUM:
            begin
                w.ld_sum = 1'b1;
            end
            STEP_TEST:
            begin
                w.cond   = JMP_YZERO;
                w.target = STEP_FIN;
            end
            STEP_REM:
            begin
                w.div_go = 1'b1;
                w.dsel   = DSEL_XY;
            end
            STEP_REM_WAIT:
            begin
                w.wt     = WAIT_DIV;
                w.st     = STORE_EUCLID;
                w.cond   = JMP_ALWAYS;
                w.target = STEP_TEST;
            end
            STEP_FIN:
            begin
                w.div_go = 1'b1;
                w.dsel   = DSEL_NG;
                w.cond   = JMP_GZERO;
                w.target = STEP_OUT;
            end
            STEP_QN_WAIT:
            begin
                w.wt = WAIT_DIV;
                w.st = STORE_QN;
            end
            STEP_QD:
            begin
                w.div_go = 1'b1;
                w.dsel   = DSEL_DG;
            end
            STEP_QD_WAIT:
            begin
                w.wt = WAIT_DIV;
                w.st = STORE_QD;
            end
            STEP_OUT:
            begin
                w.wt     = WAIT_OUT;
                w.ld_out = 1'b1;
                w.cond   = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- sv/fadd_div.sv -----
module fadd_div
    import fadd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    input  logic [MAG_W-1:0] divisor,
    output logic             done,
    output logic [MAG_W-1:0] quo,
    output logic [MAG_W-1:0] rem
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [MAG_W-1:0] den_reg, den_next;
    logic [MAG_W:0]   shifted;
    logic [MAG_W:0]   diff;
    logic             ge;

    // One quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(MAG_W);
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            rem_next = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = (cnt_reg == '0);
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- sv/fadd_seq.sv -----
module fadd_seq
    import fadd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl,
    output logic    go
);

    step_t step_reg, step_next;
    step_t step_inc;

    assign step_inc = step_t'(step_reg + 4'd1);

    // Outputs: fetch the control word, evaluate the hold condition
    always_comb
    begin
        ctrl = ucode_rom(step_reg);
        unique case (ctrl.wt)
            WAIT_NONE: go = 1'b1;
            WAIT_IN:   go = status.in_valid;
            WAIT_DIV:  go = status.div_done;
            WAIT_OUT:  go = status.out_free;
            default:   go = 1'b0;
        endcase
    end

    // Next step: hold, advance or jump
    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            unique case (ctrl.cond)
                JMP_NEXT:   step_next = step_inc;
                JMP_ALWAYS: step_next = ctrl.target;
                JMP_YZERO:  step_next = status.y_zero ? ctrl.target : step_inc;
                JMP_GZERO:  step_next = status.g_zero ? ctrl.target : step_inc;
                default:    step_next = STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- sv/fadd_dp.sv -----
module fadd_dp
    import fadd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_t               ctrl,
    input  logic                go,
    output status_t             status,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tuser,
    output logic                div_start,
    output logic [MAG_W-1:0]    div_a,
    output logic [MAG_W-1:0]    div_b,
    input  logic                div_done,
    input  logic [MAG_W-1:0]    div_quo,
    input  logic [MAG_W-1:0]    div_rem
);

    logic signed [IN_WIDTH-1:0] na, da, nb, db;
    logic signed [PROD_W-1:0]   pa_reg, pb_reg, pd_reg;
    logic signed [NSUM_W-1:0]   nsum;
    logic        [NSUM_W-1:0]   nabs;
    logic        [MAG_W-1:0]    dabs;
    logic        [MAG_W-1:0]    x_reg, y_reg, nmag_reg, dmag_reg;
    logic        [MAG_W-1:0]    qn_reg, qd_reg;
    logic                       neg_reg;
    logic signed [NSUM_W-1:0]   qs, num_val;
    logic                       err;
    logic                       in_fire;
    logic                       out_load;
    logic                       ov_reg;
    logic        [SUM_NUM_W-1:0] out_num_reg;
    logic        [SUM_DEN_W-1:0] out_den_reg;
    logic                        out_err_reg;

    assign na = s_axis_tdata[IN_WIDTH-1:0];
    assign da = s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH];
    assign nb = s_axis_tdata[3*IN_WIDTH-1:2*IN_WIDTH];
    assign db = s_axis_tdata[4*IN_WIDTH-1:3*IN_WIDTH];

    assign s_axis_tready = (ctrl.wt == WAIT_IN);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_load      = ctrl.ld_out & go;

    // Cross products and the product denominator, taken at the input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pa_reg <= PROD_W'(na) * PROD_W'(db);
            pb_reg <= PROD_W'(nb) * PROD_W'(da);
            pd_reg <= PROD_W'(da) * PROD_W'(db);
        end
    end

    assign nsum = NSUM_W'(pa_reg) + NSUM_W'(pb_reg);
    assign nabs = nsum[NSUM_W-1] ? NSUM_W'(-nsum) : NSUM_W'(nsum);
    assign dabs = pd_reg[PROD_W-1] ? MAG_W'(-pd_reg) : MAG_W'(pd_reg);

    // Euclid on magnitudes; sign is restored at the end
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_sum)
        begin
            x_reg    <= dabs;
            y_reg    <= nabs[MAG_W-1:0];
            nmag_reg <= nabs[MAG_W-1:0];
            dmag_reg <= dabs;
            neg_reg  <= (nsum[NSUM_W-1] ^ pd_reg[PROD_W-1]) & (pd_reg != '0);
        end
        else if (go)
        begin
            unique case (ctrl.st)
                STORE_EUCLID:
                begin
                    x_reg <= y_reg;
                    y_reg <= div_rem;
                end
                STORE_QN: qn_reg <= div_quo;
                STORE_QD: qd_reg <= div_quo;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        div_start = ctrl.div_go;
        unique case (ctrl.dsel)
            DSEL_XY:
            begin
                div_a = x_reg;
                div_b = y_reg;
            end
            DSEL_NG:
            begin
                div_a = nmag_reg;
                div_b = x_reg;
            end
            DSEL_DG:
            begin
                div_a = dmag_reg;
                div_b = x_reg;
            end
            default:
            begin
                div_a = x_reg;
                div_b = y_reg;
            end
        endcase
    end

    // Result formatting: zero gcd means numerator and denominator were both zero
    assign err     = (x_reg == '0);
    assign qs      = signed'({1'b0, qn_reg});
    assign num_val = neg_reg ? -qs : qs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_err_reg <= err;
            out_num_reg <= err ? '0 : SUM_NUM_W'(num_val);
            out_den_reg <= err ? '0 : SUM_DEN_W'(qd_reg);
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = M_DATA_W'({out_den_reg, out_num_reg});
    assign m_axis_tuser  = out_err_reg;

    assign status.in_valid = s_axis_tvalid;
    assign status.div_done = div_done;
    assign status.out_free = ~ov_reg | m_axis_tready;
    assign status.y_zero   = (y_reg == '0);
    assign status.g_zero   = (x_reg == '0);

endmodule

// ----- sv/fraction_add_reduce.sv -----
// Fraction adder with gcd reduction.
// Input stream: one beat carries num_a/den_a + num_b/den_b. The block forms
// n = num_a*den_b + num_b*den_a over d = den_a*den_b, reduces both by the
// Euclid gcd and returns the sum with a non-negative denominator.
// Output stream: one beat per input beat; tuser flags the 0/0 case, where
// both result fields are zero. A zero denominator over a nonzero numerator
// gives 1/0, a zero numerator gives 0/1.
// Each item takes a data-dependent number of Euclid remainder steps (0 up
// to about 45); in the 0/0 case the sequencer goes straight to its output step.
// Every remainder and both final quotients go through one shared divider,
// one quotient bit per cycle, under a small microcode sequencer.
// s_axis_tready is high only while the sequencer sits at its idle step.
// The result waits in an output register: a stalled receiver holds it there
// while the next item is already accepted and worked on; the sequencer
// holds at its output step until that register is free.
// Reset clears the step counter, the divider count and output valid.
module fraction_add_reduce
    import fadd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // num_a, den_a, num_b, den_b
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // sum_num, sum_den
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // zero_over_zero
    output logic                m_axis_tuser
);

    ctrl_t            ctrl;
    status_t          status;
    logic             go;
    logic             div_start;
    logic             div_done;
    logic [MAG_W-1:0] div_a, div_b, div_quo, div_rem;

    // Program sequencer
    fadd_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .go     (go)
    );

    // Operand registers, stream ports and result formatting
    fadd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .go            (go),
        .status        (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .div_start     (div_start),
        .div_a         (div_a),
        .div_b         (div_b),
        .div_done      (div_done),
        .div_quo       (div_quo),
        .div_rem       (div_rem)
    );

    // Shared divider: Euclid remainders and the two final quotients
    fadd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

endmodule
